// ----- hdl/edgs_pkg.sv -----
// Shared types and constants of the event-driven gate simulator.
// No dependencies.
package edgs_pkg;

  localparam int unsigned GateAw   = 10;
  localparam int unsigned WireAw   = 12;
  localparam int unsigned ListAw   = 12;
  localparam int unsigned EvAw     = 12;
  localparam int unsigned EvCntW   = EvAw + 1;
  localparam int unsigned WireCntW = 13;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned MaxGates = 1 << GateAw;
  localparam int unsigned MaxWires = 1 << WireAw;

  localparam logic [7:0] MaxRoundsRst = 8'd100;

  typedef enum logic [2:0] {
    OpGate, OpWire, OpFanin, OpFanout, OpSetOut, OpRun, OpReadOut, OpReadWire
  } op_e;

  typedef enum logic [3:0] {
    GtSrc0 = 4'd0, GtSrc1 = 4'd1, GtOut = 4'd2, GtAnd = 4'd3, GtOr = 4'd4,
    GtNot = 4'd5, GtNand = 4'd6, GtNor = 4'd7, GtXor = 4'd8, GtXnor = 4'd9
  } gate_type_e;

  localparam logic [CfgIdxW-1:0] CfgWireCount = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxRounds = 4'd1;

  typedef enum logic [4:0] {
    SClr, SIdle, SRead, SScRd, SScGate, SScSlot, SScCmp,
    SEvPop, SEvGate, SEvSlot, SEvOld, SFiAddr, SFiWire, SFiAcc,
    SEval, SFoAddr, SFoWire, SFoPush, SEvNext, SFin
  } state_e;

  typedef struct packed {
    logic [3:0]  gate_type;
    logic [9:0]  output_slot;
    logic [11:0] fanin_start;
    logic [7:0]  fanin_size;
    logic [11:0] fanout_start;
    logic [7:0]  fanout_size;
  } gate_rec_t;

  typedef struct packed {
    logic [9:0] src;
    logic [9:0] dst;
  } wire_end_t;

  typedef struct packed {
    logic first;
    logic and_v;
    logic or_v;
    logic xor_v;
  } acc_t;

endpackage

// ----- hdl/edgs_if.sv -----
// Handshake channels of the event-driven gate simulator: items, results, config.
// Depends on edgs_pkg.
interface edgs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [11:0] index;
  logic [3:0]  gate_type;
  logic [9:0]  output_slot;
  logic [11:0] fanin_start;
  logic [7:0]  fanin_size;
  logic [11:0] fanout_start;
  logic [7:0]  fanout_size;
  logic [9:0]  source_gate;
  logic [9:0]  dest_gate;
  logic [11:0] wire_number;
  logic        bit_value;
  modport source (output valid, operation, index, gate_type, output_slot, fanin_start,
                  fanin_size, fanout_start, fanout_size, source_gate, dest_gate,
                  wire_number, bit_value, input ready);
  modport sink (input valid, operation, index, gate_type, output_slot, fanin_start,
                fanin_size, fanout_start, fanout_size, source_gate, dest_gate,
                wire_number, bit_value, output ready);
endinterface

interface edgs_out_if;
  logic       valid;
  logic       ready;
  logic       read_value;
  logic       run_changed;
  logic       event_overflow;
  logic [7:0] rounds_used;
  modport source (output valid, read_value, run_changed, event_overflow, rounds_used,
                  input ready);
  modport sink (input valid, read_value, run_changed, event_overflow, rounds_used,
                output ready);
endinterface

interface edgs_cfg_if;
  import edgs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/edgs_eval.sv -----
// Gate function: new output of one gate from its accumulated fanin values.
// Depends on edgs_pkg.
module edgs_eval (
  input  logic [3:0]     gate_type_i,
  input  logic           has_fanin_i,
  input  edgs_pkg::acc_t acc_i,
  input  logic           old_i,
  output logic           value_o
);
  import edgs_pkg::*;

  always_comb begin
    case (gate_type_e'(gate_type_i))
      GtSrc0, GtSrc1: value_o = has_fanin_i ? acc_i.first : old_i;
      GtOut:          value_o = acc_i.first;
      GtAnd:          value_o = acc_i.and_v;
      GtOr:           value_o = acc_i.or_v;
      GtNot:          value_o = ~acc_i.first;
      GtNand:         value_o = ~acc_i.and_v;
      GtNor:          value_o = ~acc_i.or_v;
      GtXor:          value_o = acc_i.xor_v;
      GtXnor:         value_o = ~acc_i.xor_v;
      default:        value_o = old_i;
    endcase
  end
endmodule

// ----- hdl/event_driven_gate_simulator_top.sv -----
// Event-driven gate simulator: netlist memories, scan and event sequencer.
// Depends on edgs_pkg, edgs_if.sv and edgs_eval.
// Load items answer in the cycle after they are taken; reads go through SRead. A run
// scans every wire (also the driving source gate's output), then handles each event
// with its fanin and fanout entries, bound by the single read port of each memory.
// One item at a time. Reset: clearing pass over output and wire values; no items then.
module event_driven_gate_simulator_top (
  input  logic clk_i,
  input  logic rst_ni,
  edgs_in_if.sink    in_i,
  edgs_out_if.source res_o,
  edgs_cfg_if.sink   cfg_i
);
  import edgs_pkg::*;

  state_e state_q, state_d;

  logic [WireCntW-1:0] wire_count_q;
  logic [7:0]          max_rounds_q;

  gate_rec_t gate_mem [MaxGates];
  logic      ov_mem   [MaxGates];
  wire_end_t we_mem   [MaxWires];
  logic      ws_mem   [MaxWires];
  logic [WireAw-1:0] fi_mem [1 << ListAw];
  logic [WireAw-1:0] fo_mem [1 << ListAw];
  logic [GateAw-1:0] ev0_mem [1 << EvAw];
  logic [GateAw-1:0] ev1_mem [1 << EvAw];

  logic gm_we; logic [GateAw-1:0] gm_wa, gm_ra; gate_rec_t gm_wd, gm_rd_q;
  logic ov_we, ov_wd, ov_rd_q; logic [GateAw-1:0] ov_wa, ov_ra;
  logic wm_we; logic [WireAw-1:0] wm_wa, wm_ra; wire_end_t wm_wd, wm_rd_q;
  logic ws_we, ws_wd, ws_rd_q; logic [WireAw-1:0] ws_wa, ws_ra;
  logic fi_we; logic [ListAw-1:0] fi_wa, fi_ra; logic [WireAw-1:0] fi_wd, fi_rd_q;
  logic fo_we; logic [ListAw-1:0] fo_wa, fo_ra; logic [WireAw-1:0] fo_wd, fo_rd_q;
  logic [1:0] ev_we; logic [EvAw-1:0] ev_wa, ev_ra;
  logic [GateAw-1:0] ev_wd, ev0_rd_q, ev1_rd_q, ev_rd;

  logic [WireAw-1:0]   clr_q, clr_d;
  logic [WireCntW-1:0] wi_q, wi_d, n_q, n_d;
  logic [EvCntW-1:0]   cur_q, cur_d, nxt_q, nxt_d;
  logic [7:0]          rounds_q, rounds_d, k_q, k_d;
  logic                sel_q, sel_d, ovf_q, ovf_d, chg_q, chg_d;
  logic                sig_q, sig_d, old_q, old_d, nv_q, nv_d;
  logic [GateAw-1:0]   dst_q, dst_d;
  gate_rec_t           rec_q, rec_d;
  acc_t                acc_q, acc_d;
  logic                rd_wire_q, rd_wire_d, rd_ok_q, rd_ok_d;
  logic                nv;

  logic       out_valid_q, out_valid_d, out_load;
  logic       out_rv_q, out_rv_d, out_chg_q, out_chg_d, out_ovf_q, out_ovf_d;
  logic [7:0] out_rnd_q, out_rnd_d;

  logic                in_acc;
  logic [EvCntW-1:0]   new_cur;
  logic [7:0]          new_rounds;
  logic [WireCntW-1:0] wc_lim;
  logic                scan_done, src_type, ev_last, go_on;

  assign in_i.ready  = (state_q == SIdle) && (!out_valid_q || res_o.ready);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign ev_rd       = sel_q ? ev1_rd_q : ev0_rd_q;
  assign wc_lim      = wire_count_q > WireCntW'(MaxWires) ? WireCntW'(MaxWires)
                                                          : wire_count_q;
  assign scan_done   = (wi_q == n_q);
  assign src_type    = (gm_rd_q.gate_type == GtSrc0) || (gm_rd_q.gate_type == GtSrc1);
  assign ev_last     = (cur_q == '0);
  assign new_cur     = ev_last ? nxt_q : cur_q;
  assign new_rounds  = ev_last ? rounds_q + 8'd1 : rounds_q;
  assign go_on       = (new_cur != '0) && (new_rounds < max_rounds_q);

  edgs_eval u_eval (
    .gate_type_i (rec_q.gate_type),
    .has_fanin_i (rec_q.fanin_size != 8'd0),
    .acc_i       (acc_q),
    .old_i       (old_q),
    .value_o     (nv)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SClr:    if (clr_q == '1) state_d = SIdle;
      SIdle: begin
        if (in_acc) begin
          unique case (op_e'(in_i.operation))
            OpRun:                 state_d = SScRd;
            OpReadOut, OpReadWire: state_d = SRead;
            default:               state_d = SIdle;
          endcase
        end
      end
      SRead:   state_d = SIdle;
      SScRd: begin
        if (!scan_done) state_d = SScGate;
        else if (cur_q != '0 && max_rounds_q != 8'd0) state_d = SEvPop;
        else state_d = SFin;
      end
      SScGate: state_d = SScSlot;
      SScSlot: state_d = src_type ? SScCmp : SScRd;
      SScCmp:  state_d = SScRd;
      SEvPop:  state_d = SEvGate;
      SEvGate: state_d = SEvSlot;
      SEvSlot: state_d = SEvOld;
      SEvOld:  state_d = (rec_q.fanin_size == 8'd0) ? SEval : SFiAddr;
      SFiAddr: state_d = SFiWire;
      SFiWire: state_d = SFiAcc;
      SFiAcc:  state_d = (k_q == rec_q.fanin_size - 8'd1) ? SEval : SFiAddr;
      SEval:   state_d = (nv != old_q && rec_q.fanout_size != 8'd0) ? SFoAddr : SEvNext;
      SFoAddr: state_d = SFoWire;
      SFoWire: state_d = SFoPush;
      SFoPush: state_d = (k_q == rec_q.fanout_size - 8'd1) ? SEvNext : SFoAddr;
      SEvNext: state_d = go_on ? SEvPop : SFin;
      SFin:    state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // datapath and memory control
  always_comb begin
    gm_we = 1'b0; gm_wa = in_i.index[GateAw-1:0]; gm_ra = '0;
    gm_wd = '{in_i.gate_type, in_i.output_slot, in_i.fanin_start, in_i.fanin_size,
              in_i.fanout_start, in_i.fanout_size};
    ov_we = 1'b0; ov_wa = clr_q[GateAw-1:0]; ov_wd = 1'b0; ov_ra = '0;
    wm_we = 1'b0; wm_wa = in_i.index; wm_wd = '{in_i.source_gate, in_i.dest_gate};
    wm_ra = '0;
    ws_we = 1'b0; ws_wa = clr_q; ws_wd = 1'b0; ws_ra = '0;
    fi_we = 1'b0; fi_wa = in_i.index; fi_wd = in_i.wire_number; fi_ra = '0;
    fo_we = 1'b0; fo_wa = in_i.index; fo_wd = in_i.wire_number; fo_ra = '0;
    ev_we = 2'b00; ev_wa = '0; ev_wd = '0; ev_ra = '0;
    clr_d = clr_q; wi_d = wi_q; n_d = n_q; cur_d = cur_q; nxt_d = nxt_q;
    rounds_d = rounds_q; k_d = k_q; sel_d = sel_q; ovf_d = ovf_q; chg_d = chg_q;
    sig_d = sig_q; old_d = old_q; nv_d = nv_q; dst_d = dst_q; rec_d = rec_q;
    acc_d = acc_q; rd_wire_d = rd_wire_q; rd_ok_d = rd_ok_q;
    out_load = 1'b0; out_rv_d = out_rv_q; out_chg_d = out_chg_q;
    out_ovf_d = out_ovf_q; out_rnd_d = out_rnd_q;
    unique case (state_q)
      SClr: begin
        ov_we = 1'b1; ws_we = 1'b1; clr_d = clr_q + 1'b1;
      end
      SIdle: begin
        if (in_acc) begin
          out_rv_d = 1'b0; out_chg_d = 1'b0; out_ovf_d = 1'b0; out_rnd_d = '0;
          unique case (op_e'(in_i.operation))
            OpGate: begin
              gm_we = (in_i.index[WireAw-1:GateAw] == '0); out_load = 1'b1;
            end
            OpWire: begin
              wm_we = 1'b1; ws_we = 1'b1; ws_wa = in_i.index; ws_wd = in_i.bit_value;
              out_load = 1'b1;
            end
            OpFanin:  begin fi_we = 1'b1; out_load = 1'b1; end
            OpFanout: begin fo_we = 1'b1; out_load = 1'b1; end
            OpSetOut: begin
              ov_we = (in_i.index[WireAw-1:GateAw] == '0);
              ov_wa = in_i.index[GateAw-1:0]; ov_wd = in_i.bit_value; out_load = 1'b1;
            end
            OpRun: begin
              wi_d = '0; n_d = wc_lim; cur_d = '0; nxt_d = '0; rounds_d = '0;
              sel_d = 1'b0; ovf_d = 1'b0; chg_d = 1'b0;
            end
            OpReadOut: begin
              ov_ra = in_i.index[GateAw-1:0]; rd_wire_d = 1'b0;
              rd_ok_d = (in_i.index[WireAw-1:GateAw] == '0);
            end
            OpReadWire: begin
              ws_ra = in_i.index; rd_wire_d = 1'b1; rd_ok_d = 1'b1;
            end
          endcase
        end
      end
      SRead: begin
        out_load = 1'b1;
        out_rv_d = rd_ok_q & (rd_wire_q ? ws_rd_q : ov_rd_q);
      end
      SScRd: begin
        wm_ra = wi_q[WireAw-1:0]; ws_ra = wi_q[WireAw-1:0];
        if (scan_done && cur_q != '0) chg_d = 1'b1;
      end
      SScGate: begin
        sig_d = ws_rd_q; dst_d = wm_rd_q.dst; gm_ra = wm_rd_q.src;
      end
      SScSlot: begin
        ov_ra = gm_rd_q.output_slot;
        if (!src_type) wi_d = wi_q + 1'b1;
      end
      SScCmp: begin
        wi_d = wi_q + 1'b1;
        if (ov_rd_q != sig_q) begin
          ws_we = 1'b1; ws_wa = wi_q[WireAw-1:0]; ws_wd = ov_rd_q;
          if (cur_q[EvCntW-1]) ovf_d = 1'b1;
          else begin
            ev_we[sel_q] = 1'b1; ev_wa = cur_q[EvAw-1:0]; ev_wd = dst_q;
            cur_d = cur_q + 1'b1;
          end
        end
      end
      SEvPop: begin
        cur_d = cur_q - 1'b1; ev_ra = cur_d[EvAw-1:0];
      end
      SEvGate: gm_ra = ev_rd;
      SEvSlot: begin
        rec_d = gm_rd_q; ov_ra = gm_rd_q.output_slot; k_d = '0;
        acc_d = '{first: 1'b0, and_v: 1'b1, or_v: 1'b0, xor_v: 1'b0};
      end
      SEvOld:  old_d = ov_rd_q;
      SFiAddr: fi_ra = rec_q.fanin_start + ListAw'(k_q);
      SFiWire: ws_ra = fi_rd_q;
      SFiAcc: begin
        if (k_q == '0) acc_d.first = ws_rd_q;
        acc_d.and_v = acc_q.and_v & ws_rd_q;
        acc_d.or_v  = acc_q.or_v | ws_rd_q;
        acc_d.xor_v = acc_q.xor_v ^ ws_rd_q;
        k_d = k_q + 8'd1;
      end
      SEval: begin
        ov_we = 1'b1; ov_wa = rec_q.output_slot; ov_wd = nv; nv_d = nv; k_d = '0;
      end
      SFoAddr: fo_ra = rec_q.fanout_start + ListAw'(k_q);
      SFoWire: begin
        ws_we = 1'b1; ws_wa = fo_rd_q; ws_wd = nv_q; wm_ra = fo_rd_q;
      end
      SFoPush: begin
        k_d = k_q + 8'd1;
        if (nxt_q[EvCntW-1]) ovf_d = 1'b1;
        else begin
          ev_we[~sel_q] = 1'b1; ev_wa = nxt_q[EvAw-1:0]; ev_wd = wm_rd_q.dst;
          nxt_d = nxt_q + 1'b1;
        end
      end
      SEvNext: begin
        if (ev_last) begin
          sel_d = ~sel_q; cur_d = nxt_q; nxt_d = '0; rounds_d = new_rounds;
        end
      end
      SFin: begin
        out_load = 1'b1; out_chg_d = chg_q; out_ovf_d = ovf_q; out_rnd_d = rounds_q;
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i) begin
    if (gm_we) gate_mem[gm_wa] <= gm_wd;
    gm_rd_q <= gate_mem[gm_ra];
  end
  always_ff @(posedge clk_i) begin
    if (ov_we) ov_mem[ov_wa] <= ov_wd;
    ov_rd_q <= ov_mem[ov_ra];
  end
  always_ff @(posedge clk_i) begin
    if (wm_we) we_mem[wm_wa] <= wm_wd;
    wm_rd_q <= we_mem[wm_ra];
  end
  always_ff @(posedge clk_i) begin
    if (ws_we) ws_mem[ws_wa] <= ws_wd;
    ws_rd_q <= ws_mem[ws_ra];
  end
  always_ff @(posedge clk_i) begin
    if (fi_we) fi_mem[fi_wa] <= fi_wd;
    fi_rd_q <= fi_mem[fi_ra];
  end
  always_ff @(posedge clk_i) begin
    if (fo_we) fo_mem[fo_wa] <= fo_wd;
    fo_rd_q <= fo_mem[fo_ra];
  end
  always_ff @(posedge clk_i) begin
    if (ev_we[0]) ev0_mem[ev_wa] <= ev_wd;
    ev0_rd_q <= ev0_mem[ev_ra];
  end
  always_ff @(posedge clk_i) begin
    if (ev_we[1]) ev1_mem[ev_wa] <= ev_wd;
    ev1_rd_q <= ev1_mem[ev_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SClr;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      wire_count_q <= '0;
      max_rounds_q <= MaxRoundsRst;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          CfgWireCount: wire_count_q <= cfg_i.data;
          CfgMaxRounds: max_rounds_q <= cfg_i.data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wi_q <= wi_d; n_q <= n_d; cur_q <= cur_d; nxt_q <= nxt_d;
    rounds_q <= rounds_d; k_q <= k_d; sel_q <= sel_d; ovf_q <= ovf_d; chg_q <= chg_d;
    sig_q <= sig_d; old_q <= old_d; nv_q <= nv_d; dst_q <= dst_d; rec_q <= rec_d;
    acc_q <= acc_d; rd_wire_q <= rd_wire_d; rd_ok_q <= rd_ok_d;
    out_rv_q <= out_rv_d; out_chg_q <= out_chg_d; out_ovf_q <= out_ovf_d;
    out_rnd_q <= out_rnd_d;
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.read_value     = out_rv_q;
  assign res_o.run_changed    = out_chg_q;
  assign res_o.event_overflow = out_ovf_q;
  assign res_o.rounds_used    = out_rnd_q;

endmodule
